@@ sv/pcs_pkg.sv @@
// Shared types for the prime count sieve: controller commands and datapath status.
`timescale 1ns / 1ps
`default_nettype none
package pcs_pkg;

	localparam int CNT_W = 16;

	typedef struct packed {
		logic load;       // capture limit, reset counters
		logic fill;       // write one at ptr, advance ptr
		logic outer_rd;   // read store at i
		logic mark_init;  // k = 2i
		logic mark;       // write zero at k, k += i
		logic next_i;     // i += 1, square tracker follows
		logic cnt_init;   // ptr = 2
		logic cnt_rd;     // read store at ptr, advance ptr
	} pcs_cmd_t;

	typedef struct packed {
		logic limit_low;  // saturated input limit below two
		logic ptr_at_n;   // fill / count pointer at the limit
		logic outer_go;   // i within the outer bound
		logic bit_set;    // registered read data
		logic k_over;     // multiple past the limit
	} pcs_stat_t;

endpackage
`default_nettype wire

@@ sv/pcs_ctrl.sv @@
// Controller state machine for the prime count sieve.
`timescale 1ns / 1ps
`default_nettype none
module pcs_ctrl (
	input  wire               clk,
	input  wire               arst_n,
	input  wire               in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  wire               out_ready,
	input  pcs_pkg::pcs_stat_t stat,
	output pcs_pkg::pcs_cmd_t  cmd
);
	import pcs_pkg::*;

	typedef enum logic [7:0] {
		S_IDLE  = 8'b0000_0001,
		S_FILL  = 8'b0000_0010,
		S_ORD   = 8'b0000_0100,
		S_OCHK  = 8'b0000_1000,
		S_MARK  = 8'b0001_0000,
		S_CNT   = 8'b0010_0000,
		S_CTAIL = 8'b0100_0000,
		S_DONE  = 8'b1000_0000
	} state_t;

	state_t state_q;
	state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		out_valid = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d  = stat.limit_low ? S_DONE : S_FILL;
				end
			end
			S_FILL: begin
				cmd.fill = 1'b1;
				if (stat.ptr_at_n) begin
					state_d = S_ORD;
				end
			end
			S_ORD: begin
				if (stat.outer_go) begin
					cmd.outer_rd = 1'b1;
					state_d      = S_OCHK;
				end else begin
					cmd.cnt_init = 1'b1;
					state_d      = S_CNT;
				end
			end
			S_OCHK: begin
				// read data of i is registered by now
				if (stat.bit_set) begin
					cmd.mark_init = 1'b1;
					state_d       = S_MARK;
				end else begin
					cmd.next_i = 1'b1;
					state_d    = S_ORD;
				end
			end
			S_MARK: begin
				if (stat.k_over) begin
					cmd.next_i = 1'b1;
					state_d    = S_ORD;
				end else begin
					cmd.mark = 1'b1;
				end
			end
			S_CNT: begin
				cmd.cnt_rd = 1'b1;
				if (stat.ptr_at_n) begin
					state_d = S_CTAIL;
				end
			end
			S_CTAIL: begin
				// last read lands in the count at this edge
				state_d = S_DONE;
			end
			S_DONE: begin
				out_valid = 1'b1;
				if (out_ready) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule
`default_nettype wire

@@ sv/pcs_dp.sv @@
// Datapath for the prime count sieve: bit store, loop counters and prime counter.
`timescale 1ns / 1ps
`default_nettype none
module pcs_dp #(
	parameter int MAX_LIMIT = 65535
) (
	input  wire                        clk,
	input  wire                        arst_n,
	input  pcs_pkg::pcs_cmd_t          cmd,
	input  wire [15:0]                 upper_limit,
	output pcs_pkg::pcs_stat_t         stat,
	output logic [pcs_pkg::CNT_W-1:0]  prime_count
);
	import pcs_pkg::*;

	localparam int DEPTH = MAX_LIMIT + 1;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;

	logic [AW-1:0]    n_sat;
	logic [AW-1:0]    n_q;
	logic [CW-1:0]    n_ext;
	logic [CW-1:0]    ptr_q;
	logic [CW-1:0]    i_q;
	logic [CW-1:0]    pq_q;     // (i-1)^2
	logic [CW-1:0]    k_q;
	logic [CNT_W-1:0] count_q;
	logic             vld_s1;

	logic             mem_q [DEPTH];
	logic             rdata_q;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic             rd_en;
	logic [AW-1:0]    rd_addr;

	assign n_sat = (32'(upper_limit) > MAX_LIMIT) ? AW'(MAX_LIMIT) : AW'(upper_limit);
	assign n_ext = {1'b0, n_q};

	assign stat.limit_low = (n_sat < AW'(2));
	assign stat.ptr_at_n  = (ptr_q == n_ext);
	assign stat.outer_go  = (i_q == CW'(2)) || (pq_q < n_ext);
	assign stat.bit_set   = rdata_q;
	assign stat.k_over    = (k_q > n_ext);

	assign wr_en   = cmd.fill | cmd.mark;
	assign wr_addr = cmd.fill ? ptr_q[AW-1:0] : k_q[AW-1:0];
	assign rd_en   = cmd.outer_rd | cmd.cnt_rd;
	assign rd_addr = cmd.outer_rd ? i_q[AW-1:0] : ptr_q[AW-1:0];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= cmd.fill;
		end
		if (rd_en) begin
			rdata_q <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q <= n_sat;
		end
		if (cmd.load) begin
			ptr_q <= '0;
		end else if (cmd.cnt_init) begin
			ptr_q <= CW'(2);
		end else if (cmd.fill | cmd.cnt_rd) begin
			ptr_q <= ptr_q + CW'(1);
		end
		if (cmd.load) begin
			i_q  <= CW'(2);
			pq_q <= CW'(1);
		end else if (cmd.next_i) begin
			i_q  <= i_q + CW'(1);
			pq_q <= pq_q + {i_q[CW-2:0], 1'b0} - CW'(1);
		end
		if (cmd.mark_init) begin
			k_q <= {i_q[CW-2:0], 1'b0};
		end else if (cmd.mark) begin
			k_q <= k_q + i_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1  <= 1'b0;
			count_q <= '0;
		end else begin
			vld_s1 <= cmd.cnt_rd;
			if (cmd.load) begin
				count_q <= '0;
			end else if (vld_s1) begin
				count_q <= count_q + CNT_W'(rdata_q);
			end
		end
	end

	assign prime_count = count_q;

endmodule
`default_nettype wire

@@ sv/prime_count_sieve.sv @@
// Top level of the prime count sieve: controller plus datapath.
//
//  channel | signals                        | moves
//  --------+--------------------------------+-------------------------------
//  in      | in_valid, in_ready, upper_limit| one request per transfer
//  out     | out_valid, out_ready, prime_count | one count per request
//
// One request at a time. A limit n of two or more goes through the fill of the
// store, a read of each outer index up to max(2, ceil(sqrt n)), the marking of
// multiples of each index still set, the count reads from 2 to n and a tail state
// before out_valid; the controller gives the bit store one access at a time.
// A limit below two raises out_valid in the cycle after its transfer.
// Reset clears the controller and counter; the store needs no clearing pass.
// in_ready is high only while idle; a stalled result holds in DONE.
`timescale 1ns / 1ps
`default_nettype none
module prime_count_sieve #(
	parameter int MAX_LIMIT = 65535
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         in_valid,
	output logic        in_ready,
	input  wire  [15:0] upper_limit,
	output logic        out_valid,
	input  wire         out_ready,
	output logic [15:0] prime_count
);
	import pcs_pkg::*;

	pcs_cmd_t  cmd;
	pcs_stat_t stat;

	pcs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	pcs_dp #(
		.MAX_LIMIT (MAX_LIMIT)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.upper_limit (upper_limit),
		.stat        (stat),
		.prime_count (prime_count)
	);

endmodule
`default_nettype wire

@@ tb/prime_count_sieve_test.sv @@
// Self-checking testbench for prime_count_sieve: directed and random limits, stalls on both sides.
`timescale 1ns / 1ps
module prime_count_sieve_test;

	localparam int SIEVE_MAX = 65535;
	localparam int IDLE_LIMIT = 1_500_000;

	typedef enum int {RX_OPEN, RX_SPARSE, RX_COIN} rx_pattern_e;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [15:0] upper_limit = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [15:0] prime_count;

	logic [15:0] expected_counts[$];
	bit          sieve_bits [0:SIEVE_MAX];
	int          mismatch_count = 0;
	int          burst_left = 0;
	bit          sender_steady = 1'b0;
	int          hold_request = 0;
	int          hold_left = 0;
	rx_pattern_e rx_pattern = RX_OPEN;
	int          rx_phase = 0;
	int unsigned rx_tick = 0;
	int          idle_cycles = 0;

	prime_count_sieve u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.upper_limit(upper_limit),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.prime_count(prime_count)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	// Sieve of Eratosthenes over the limit, saturated to the store size
	function automatic logic [15:0] sieve_count(input logic [15:0] limit);
		int unsigned n, bound, i, k, total;
		n = 32'(limit);
		if (n > SIEVE_MAX)
			n = SIEVE_MAX;
		if (n < 2)
			return '0;
		for (i = 0; i <= n; i++)
			sieve_bits[i] = 1'b1;
		bound = 2;
		while (bound * bound < n)
			bound++;
		for (i = 2; i <= bound; i++) begin
			if (sieve_bits[i]) begin
				for (k = i + i; k <= n; k += i)
					sieve_bits[k] = 1'b0;
			end
		end
		total = 0;
		for (i = 2; i <= n; i++)
			total += 32'(sieve_bits[i]);
		return total[15:0];
	endfunction

	// mostly small limits; large ones are slow in the block
	function automatic logic [15:0] pick_limit();
		int unsigned roll;
		roll = $urandom_range(0, 99);
		if (roll < 5)
			return 16'($urandom_range(0, 1));
		else if (roll < 80)
			return 16'($urandom_range(2, 300));
		else if (roll < 95)
			return 16'($urandom_range(301, 4095));
		else
			return 16'($urandom_range(4096, 8191));
	endfunction

	task automatic report_mismatch(input string what);
		$display("%0t ns: MISMATCH %s", $time, what);
		mismatch_count++;
	endtask

	// valid is left high after the transfer; the next call may lower it for a gap, a drain lowers it
	task automatic send_limit(input logic [15:0] limit);
		if (!sender_steady && burst_left == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 24)) @(posedge clk);
			burst_left = $urandom_range(1, 8);
		end
		in_valid    <= 1'b1;
		upper_limit <= limit;
		do @(posedge clk); while (!in_ready);
		expected_counts.push_back(sieve_count(limit));
		if (burst_left != 0)
			burst_left--;
	endtask

	task automatic wait_all_counts();
		in_valid <= 1'b0;
		burst_left = 0;
		while (expected_counts.size() != 0)
			@(posedge clk);
	endtask

	// result check and receiver stall pattern
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (expected_counts.size() == 0)
				report_mismatch($sformatf("prime_count %0d with no request pending",
					prime_count));
			else if (prime_count !== expected_counts[0]) begin
				report_mismatch($sformatf("prime_count got %0d expected %0d",
					prime_count, expected_counts[0]));
				void'(expected_counts.pop_front());
			end else
				void'(expected_counts.pop_front());
		end
		if (hold_request != 0) begin
			hold_left = hold_request;
			hold_request = 0;
		end
		if (hold_left != 0) begin
			hold_left--;
			out_ready <= 1'b0;
		end else begin
			if (rx_phase == 0) begin
				rx_pattern = rx_pattern_e'($urandom_range(0, 2));
				rx_phase = $urandom_range(16, 128);
			end
			rx_phase--;
			case (rx_pattern)
				RX_OPEN:   out_ready <= 1'b1;
				RX_SPARSE: out_ready <= (rx_tick[1:0] == 2'd0);
				default:   out_ready <= 1'($urandom_range(0, 1));
			endcase
		end
		rx_tick++;
	end

	// watchdog: cycles with no transfer on either channel
	always @(posedge clk) begin
		if (!arst_n || (in_valid && in_ready) || (out_valid && out_ready))
			idle_cycles = 0;
		else begin
			idle_cycles++;
			if (idle_cycles >= IDLE_LIMIT) begin
				$display("DONE: errors detected");
				$finish;
			end
		end
	end

	task automatic test_tiny_limits();
		logic [15:0] limits [6] = '{16'd0, 16'd1, 16'd2, 16'd3, 16'd4, 16'd5};
		foreach (limits[j])
			send_limit(limits[j]);
		wait_all_counts();
	endtask

	// limits around perfect squares move the outer bound
	task automatic test_square_bounds();
		logic [15:0] limits [12] = '{16'd8, 16'd9, 16'd10, 16'd24, 16'd25, 16'd26,
			16'd48, 16'd49, 16'd50, 16'd120, 16'd121, 16'd122};
		foreach (limits[j])
			send_limit(limits[j]);
		wait_all_counts();
	endtask

	task automatic test_largest_limit();
		send_limit(16'hFFFF);
		wait_all_counts();
	endtask

	task automatic test_random_limits();
		for (int j = 0; j < 90; j++) begin
			if (j % 15 == 0)
				sender_steady = ($urandom_range(0, 3) == 0);
			send_limit(pick_limit());
		end
		sender_steady = 1'b0;
		wait_all_counts();
	endtask

	// receiver holds off long enough for the block to stall its input
	task automatic test_result_backpressure();
		hold_request = 4000;
		for (int j = 0; j < 8; j++)
			send_limit(16'($urandom_range(0, 60)));
		wait_all_counts();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_tiny_limits();
		test_square_bounds();
		test_largest_limit();
		test_random_limits();
		test_result_backpressure();
		repeat (32) @(posedge clk);
		if (mismatch_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/pcs_pkg.sv
sv/pcs_ctrl.sv
sv/pcs_dp.sv
sv/prime_count_sieve.sv
tb/prime_count_sieve_test.sv
